### design/ate_pkg.sv
// Shared types, constants, color functions and cursor clamp of the terminal escape engine.
`default_nettype none
package ate_pkg;

  localparam int MAX_COLS   = 256;
  localparam int MAX_ROWS   = 128;
  localparam int MAX_PARAMS = 16;

  localparam logic [23:0] DEFAULT_FG = 24'hCDD6F4;
  localparam logic [23:0] DEFAULT_BG = 24'h1E1E2E;
  localparam logic [20:0] REPL_CHAR  = 21'h00FFFD;

  localparam logic [7:0] B_BEL  = 8'h07;
  localparam logic [7:0] B_BS   = 8'h08;
  localparam logic [7:0] B_TAB  = 8'h09;
  localparam logic [7:0] B_LF   = 8'h0A;
  localparam logic [7:0] B_CR   = 8'h0D;
  localparam logic [7:0] B_ESC  = 8'h1B;
  localparam logic [7:0] B_LBR  = 8'h5B;
  localparam logic [7:0] B_RBR  = 8'h5D;
  localparam logic [7:0] B_ST   = 8'h9C;
  localparam logic [7:0] B_SEMI = 8'h3B;
  localparam logic [7:0] B_QM   = 8'h3F;
  localparam logic [7:0] B_GT   = 8'h3E;
  localparam logic [7:0] B_EXCL = 8'h21;
  localparam logic [7:0] FIN_LO = 8'h40;
  localparam logic [7:0] FIN_HI = 8'h7E;
  localparam logic [7:0] F_CUU  = 8'h41; // A
  localparam logic [7:0] F_CUD  = 8'h42; // B
  localparam logic [7:0] F_CUF  = 8'h43; // C
  localparam logic [7:0] F_CUB  = 8'h44; // D
  localparam logic [7:0] F_CHA  = 8'h47; // G
  localparam logic [7:0] F_CUP  = 8'h48; // H
  localparam logic [7:0] F_HVP  = 8'h66; // f
  localparam logic [7:0] F_ED   = 8'h4A; // J
  localparam logic [7:0] F_EL   = 8'h4B; // K
  localparam logic [7:0] F_SGR  = 8'h6D; // m

  typedef enum logic [1:0] {MODE_TEXT, MODE_ESC, MODE_CSI, MODE_OSC} mode_t;

  typedef enum logic [2:0] {
    CMD_PUT, CMD_CTRL, CMD_CSTART, CMD_CBODY, CMD_CFINAL
  } cmd_kind_t;

  // data holds a code point for CMD_PUT, else the byte in its low bits
  typedef struct packed {
    cmd_kind_t   kind;
    logic [20:0] data;
    logic        last;
  } cmd_t;

  typedef enum logic [2:0] {
    OP_WRITE, OP_CLEAR_SCREEN, OP_CLEAR_LINE, OP_SCROLL, OP_BEEP
  } op_t;

  // packed from the top down: op lands in the lowest bits
  typedef struct packed {
    logic        bold;
    logic [23:0] back;
    logic [23:0] fore;
    logic [20:0] cp;
    logic [7:0]  col;
    logic [6:0]  row;
    op_t         op;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLAMP, ST_EXEC, ST_SCROLL, ST_P0, ST_P0W, ST_P1W, ST_APPLY,
    ST_SG, ST_SGW, ST_SG1W, ST_SG2W, ST_DONE
  } back_state_t;

  function automatic logic [23:0] base_color(input logic [3:0] idx);
    logic [23:0] c;
    case (idx)
      4'd0:    c = 24'h1E1E2E;
      4'd1:    c = 24'hE78284;
      4'd2:    c = 24'hA6E3A1;
      4'd3:    c = 24'hF9E2AF;
      4'd4:    c = 24'h89B4FA;
      4'd5:    c = 24'hF5C2E7;
      4'd6:    c = 24'h94E2D5;
      4'd7:    c = 24'hCDD6F4;
      4'd8:    c = 24'h585B70;
      4'd9:    c = 24'hF38BA8;
      4'd10:   c = 24'hA6E3A1;
      4'd11:   c = 24'hF9E2AF;
      4'd12:   c = 24'h89B4FA;
      4'd13:   c = 24'hF5C2E7;
      4'd14:   c = 24'h94E2D5;
      default: c = 24'hFFFFFF;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] cube_level(input logic [2:0] x);
    logic [7:0] l;
    l = (x == 3'd0) ? 8'd0 : 8'(8'd55 + 8'(x) * 8'd40);
    return l;
  endfunction

  // xterm 256-color palette; indexes past 255 fall back to the default fg
  function automatic logic [23:0] palette(input logic [15:0] idx);
    logic [7:0]  v;
    logic [2:0]  r;
    logic [2:0]  g;
    logic [2:0]  b;
    logic [5:0]  rem;
    logic [7:0]  gray;
    logic [23:0] c;
    v    = idx[7:0] - 8'd16;
    r    = (v >= 8'd180) ? 3'd5 : (v >= 8'd144) ? 3'd4 : (v >= 8'd108) ? 3'd3 :
           (v >= 8'd72)  ? 3'd2 : (v >= 8'd36)  ? 3'd1 : 3'd0;
    rem  = 6'(v - 8'(r) * 8'd36);
    g    = (rem >= 6'd30) ? 3'd5 : (rem >= 6'd24) ? 3'd4 : (rem >= 6'd18) ? 3'd3 :
           (rem >= 6'd12) ? 3'd2 : (rem >= 6'd6)  ? 3'd1 : 3'd0;
    b    = 3'(rem - 6'(g) * 6'd6);
    gray = 8'(8'd8 + 8'(idx[7:0] - 8'd232) * 8'd10);
    if (idx < 16'd16) c = base_color(idx[3:0]);
    else if (idx <= 16'd231) c = {cube_level(r), cube_level(g), cube_level(b)};
    else if (idx <= 16'd255) c = {gray, gray, gray};
    else c = DEFAULT_FG;
    return c;
  endfunction

  function automatic logic [8:0] clamp_pos(input logic signed [17:0] v,
                                           input logic [8:0] hi);
    logic [8:0] r;
    if (v < 18'sd0) r = 9'd0;
    else if (v > $signed({9'd0, hi})) r = hi;
    else r = v[8:0];
    return r;
  endfunction

endpackage
`default_nettype wire

### design/ate_front.sv
// Front end: byte acceptance, parse modes and UTF-8 decode into commands.
`default_nettype none
module ate_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [7:0]    in_tdata,
  output logic               q_push,
  output ate_pkg::cmd_t      q_cmd,
  input  wire logic          q_full
);

  ate_pkg::mode_t mode_r, mode_nxt;
  logic [20:0]    acc_r, acc_nxt;
  logic [1:0]     pend_r, pend_nxt;
  logic           sec_v_r, sec_v_nxt;
  ate_pkg::cmd_t  sec_r, sec_nxt;

  logic           acc_beat;
  logic [7:0]     b;
  logic [20:0]    t;
  logic           bad;
  logic           cut;
  logic           xv;
  ate_pkg::cmd_t  x;
  logic           c1_v, c2_v;
  ate_pkg::cmd_t  c1, c2;

  assign in_tready = !sec_v_r && !q_full;
  assign acc_beat  = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign t         = {acc_r[14:0], b[5:0]};

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    pend_nxt = pend_r;
    bad      = 1'b0;
    cut      = 1'b0;
    xv       = 1'b0;
    x        = '{kind: ate_pkg::CMD_PUT, data: ate_pkg::REPL_CHAR, last: 1'b1};
    case (mode_r)
      ate_pkg::MODE_TEXT: begin
        if (b[7] && pend_r != 2'd0 && b[7:6] == 2'b10) begin
          if (pend_r == 2'd2 && acc_r <= 21'd15)
            bad = (t < 21'h20) || (t[20:5] == 16'h1B);
          else if (pend_r == 2'd3)
            bad = (t < 21'h10) || (t > 21'h10F);
          if (bad) begin
            pend_nxt = 2'd0;
            acc_nxt  = '0;
            xv       = 1'b1;
          end else if (pend_r == 2'd1) begin
            pend_nxt = 2'd0;
            acc_nxt  = '0;
            xv       = 1'b1;
            x.data   = t;
          end else begin
            pend_nxt = pend_r - 2'd1;
            acc_nxt  = t;
          end
        end else begin
          cut      = (pend_r != 2'd0);
          pend_nxt = 2'd0;
          acc_nxt  = '0;
          if (b[7]) begin
            if (b >= 8'hC2 && b <= 8'hDF) begin
              pend_nxt = 2'd1;
              acc_nxt  = {16'd0, b[4:0]};
            end else if (b >= 8'hE0 && b <= 8'hEF) begin
              pend_nxt = 2'd2;
              acc_nxt  = {17'd0, b[3:0]};
            end else if (b >= 8'hF0 && b <= 8'hF4) begin
              pend_nxt = 2'd3;
              acc_nxt  = {18'd0, b[2:0]};
            end else begin
              xv = 1'b1;
            end
          end else if (b == ate_pkg::B_ESC) begin
            mode_nxt = ate_pkg::MODE_ESC;
          end else if (b >= 8'h20 && b < 8'h7F) begin
            xv     = 1'b1;
            x.data = {13'd0, b};
          end else if (b == ate_pkg::B_CR || b == ate_pkg::B_LF || b == ate_pkg::B_BS ||
                       b == ate_pkg::B_TAB || b == ate_pkg::B_BEL) begin
            xv     = 1'b1;
            x.kind = ate_pkg::CMD_CTRL;
            x.data = {13'd0, b};
          end
        end
      end
      ate_pkg::MODE_ESC: begin
        if (b == ate_pkg::B_LBR) begin
          mode_nxt = ate_pkg::MODE_CSI;
          xv       = 1'b1;
          x.kind   = ate_pkg::CMD_CSTART;
        end else if (b == ate_pkg::B_RBR) begin
          mode_nxt = ate_pkg::MODE_OSC;
        end else begin
          mode_nxt = ate_pkg::MODE_TEXT;
        end
      end
      ate_pkg::MODE_CSI: begin
        xv     = 1'b1;
        x.data = {13'd0, b};
        if (b >= ate_pkg::FIN_LO && b <= ate_pkg::FIN_HI) begin
          x.kind   = ate_pkg::CMD_CFINAL;
          mode_nxt = ate_pkg::MODE_TEXT;
        end else begin
          x.kind = ate_pkg::CMD_CBODY;
        end
      end
      ate_pkg::MODE_OSC: begin
        if (b == ate_pkg::B_BEL || b == ate_pkg::B_ST) mode_nxt = ate_pkg::MODE_TEXT;
        else if (b == ate_pkg::B_ESC) mode_nxt = ate_pkg::MODE_ESC;
      end
      default: mode_nxt = ate_pkg::MODE_TEXT;
    endcase

    // a cut sequence puts U+FFFD ahead of whatever the byte itself does
    if (cut) begin
      c1_v = 1'b1;
      c1   = '{kind: ate_pkg::CMD_PUT, data: ate_pkg::REPL_CHAR, last: !xv};
      c2_v = xv;
      c2   = x;
    end else begin
      c1_v = xv;
      c1   = x;
      c2_v = 1'b0;
      c2   = x;
    end
  end

  always_comb begin
    sec_v_nxt = sec_v_r;
    sec_nxt   = sec_r;
    if (sec_v_r) begin
      q_push = !q_full;
      q_cmd  = sec_r;
      if (!q_full) sec_v_nxt = 1'b0;
    end else begin
      q_push = acc_beat && c1_v;
      q_cmd  = c1;
      if (acc_beat) begin
        sec_v_nxt = c2_v;
        sec_nxt   = c2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ate_pkg::MODE_TEXT;
      acc_r   <= '0;
      pend_r  <= '0;
      sec_v_r <= 1'b0;
    end else begin
      if (acc_beat) begin
        mode_r <= mode_nxt;
        acc_r  <= acc_nxt;
        pend_r <= pend_nxt;
      end
      sec_v_r <= sec_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sec_r <= sec_nxt;
  end

endmodule
`default_nettype wire

### design/ate_queue.sv
// Four-entry command queue between the front end and the back end.
`default_nettype none
module ate_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire ate_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output ate_pkg::cmd_t      head,
  output logic               empty,
  output logic               full
);

  ate_pkg::cmd_t mem_r [4];
  logic [1:0]    wp_r, wp_nxt;
  logic [1:0]    rp_r, rp_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign empty   = (cnt_r == 3'd0);
  assign full    = (cnt_r == 3'd4);
  assign head    = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = do_push ? wp_r + 2'd1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 2'd1 : rp_r;
    cnt_nxt = cnt_r + {2'd0, do_push} - {2'd0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_cmd;
  end

endmodule
`default_nettype wire

### design/ate_back.sv
// Back end: cursor, attributes, CSI parameters and screen command output.
`default_nettype none
module ate_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [8:0]    cols_cfg,
  input  wire logic [7:0]    rows_cfg,
  input  wire logic          q_empty,
  input  wire ate_pkg::cmd_t q_head,
  output logic               q_pop,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [87:0]        out_tdata,
  output logic               out_tlast
);

  ate_pkg::back_state_t state_r, state_nxt;
  ate_pkg::cmd_t cmd_r, cmd_nxt;
  logic [7:0]  col_r, col_nxt;
  logic [6:0]  row_r, row_nxt;
  logic [23:0] fg_r, fg_nxt, bg_r, bg_nxt;
  logic        bold_r, bold_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [1:0]  flag_r, flag_nxt;
  logic [15:0] cur_r, cur_nxt;
  logic [4:0]  n_r, n_nxt, i_r, i_nxt;
  logic [15:0] p0_r, p0_nxt, p1_r, p1_nxt;
  logic        ext_fg_r, ext_fg_nxt;
  logic        hold_v_r, hold_v_nxt;
  ate_pkg::res_t hold_r, hold_nxt;
  logic        out_v_r, out_v_nxt;
  ate_pkg::res_t out_r, out_nxt;
  logic        last_r, last_nxt;

  logic [15:0] vals [ate_pkg::MAX_PARAMS];
  logic [15:0] rdata_r;
  logic [3:0]  rd_addr;
  logic        we;
  logic [3:0]  wa;

  logic [8:0]  cols, cmax;
  logic [7:0]  rows, rmax;
  logic        out_free, emit_ok;
  logic        em_v, flush;
  ate_pkg::res_t em;
  logic [7:0]  byte_c, fin;
  logic [15:0] mv, c1;
  logic        col_wrap, row_end;
  logic [19:0] acc10;
  logic [8:0]  tab_nt;
  logic [15:0] p;
  logic        is_cup, cnt_ok;

  assign cols     = (cols_cfg < 9'd2) ? 9'd2 :
                    (cols_cfg > 9'(ate_pkg::MAX_COLS)) ? 9'(ate_pkg::MAX_COLS) : cols_cfg;
  assign rows     = (rows_cfg < 8'd2) ? 8'd2 :
                    (rows_cfg > 8'(ate_pkg::MAX_ROWS)) ? 8'(ate_pkg::MAX_ROWS) : rows_cfg;
  assign cmax     = cols - 9'd1;
  assign rmax     = rows - 8'd1;
  assign out_free = !out_v_r || out_tready;
  assign emit_ok  = !hold_v_r || out_free;
  assign byte_c   = cmd_r.data[7:0];
  assign fin      = cmd_r.data[7:0];
  assign mv       = (p0_r == 16'd0) ? 16'd1 : p0_r;
  assign c1       = (p1_r == 16'd0) ? 16'd1 : p1_r;
  assign col_wrap = ({1'b0, col_r} + 9'd1) >= cols;
  assign row_end  = ({1'b0, row_r} + 8'd1) >= rows;
  assign acc10    = {4'd0, cur_r} * 20'd10 + {16'd0, byte_c[3:0]};
  assign tab_nt   = {({1'b0, col_r[7:3]} + 6'd1), 3'd0};
  assign p        = rdata_r;
  assign is_cup   = (fin == ate_pkg::F_CUP) || (fin == ate_pkg::F_HVP);
  assign cnt_ok   = cnt_r < 5'(ate_pkg::MAX_PARAMS);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ate_pkg::ST_IDLE:  if (!q_empty) state_nxt = ate_pkg::ST_CLAMP;
      ate_pkg::ST_CLAMP: state_nxt = ate_pkg::ST_EXEC;
      ate_pkg::ST_EXEC: begin
        case (cmd_r.kind)
          ate_pkg::CMD_PUT:
            if (emit_ok)
              state_nxt = (col_wrap && row_end) ? ate_pkg::ST_SCROLL : ate_pkg::ST_DONE;
          ate_pkg::CMD_CTRL:
            if (byte_c == ate_pkg::B_LF)
              state_nxt = row_end ? ate_pkg::ST_SCROLL : ate_pkg::ST_DONE;
            else if (byte_c != ate_pkg::B_BEL || emit_ok)
              state_nxt = ate_pkg::ST_DONE;
          ate_pkg::CMD_CFINAL: state_nxt = ate_pkg::ST_P0;
          default: state_nxt = ate_pkg::ST_DONE;
        endcase
      end
      ate_pkg::ST_SCROLL: if (emit_ok) state_nxt = ate_pkg::ST_DONE;
      ate_pkg::ST_P0:     state_nxt = ate_pkg::ST_P0W;
      ate_pkg::ST_P0W:
        if (fin == ate_pkg::F_SGR) state_nxt = ate_pkg::ST_SG;
        else if (is_cup && n_r > 5'd1) state_nxt = ate_pkg::ST_P1W;
        else state_nxt = ate_pkg::ST_APPLY;
      ate_pkg::ST_P1W: state_nxt = ate_pkg::ST_APPLY;
      ate_pkg::ST_APPLY:
        if (emit_ok || !(fin == ate_pkg::F_ED || fin == ate_pkg::F_EL))
          state_nxt = ate_pkg::ST_DONE;
      ate_pkg::ST_SG: state_nxt = (i_r >= n_r) ? ate_pkg::ST_DONE : ate_pkg::ST_SGW;
      ate_pkg::ST_SGW:
        if ((p == 16'd38 || p == 16'd48) && (i_r + 5'd1) < n_r) state_nxt = ate_pkg::ST_SG1W;
        else state_nxt = ate_pkg::ST_SG;
      ate_pkg::ST_SG1W:
        state_nxt = (p == 16'd5 && (i_r + 5'd2) < n_r) ? ate_pkg::ST_SG2W : ate_pkg::ST_SG;
      ate_pkg::ST_SG2W: state_nxt = ate_pkg::ST_SG;
      ate_pkg::ST_DONE:
        if (!cmd_r.last || !hold_v_r || out_free) state_nxt = ate_pkg::ST_IDLE;
      default: state_nxt = ate_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_nxt    = cmd_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    fg_nxt     = fg_r;
    bg_nxt     = bg_r;
    bold_nxt   = bold_r;
    cnt_nxt    = cnt_r;
    flag_nxt   = flag_r;
    cur_nxt    = cur_r;
    n_nxt      = n_r;
    i_nxt      = i_r;
    p0_nxt     = p0_r;
    p1_nxt     = p1_r;
    ext_fg_nxt = ext_fg_r;
    q_pop      = 1'b0;
    em_v       = 1'b0;
    em         = '0;
    flush      = 1'b0;
    we         = 1'b0;
    wa         = cnt_r[3:0];
    rd_addr    = i_r[3:0];
    case (state_r)
      ate_pkg::ST_IDLE: begin
        q_pop   = !q_empty;
        cmd_nxt = q_head;
      end
      ate_pkg::ST_CLAMP: begin
        if ({1'b0, col_r} > cmax) col_nxt = cmax[7:0];
        if ({1'b0, row_r} > rmax) row_nxt = rmax[6:0];
      end
      ate_pkg::ST_EXEC: begin
        case (cmd_r.kind)
          ate_pkg::CMD_PUT: if (emit_ok) begin
            em_v = 1'b1;
            em   = '{bold: bold_r, back: bg_r, fore: fg_r, cp: cmd_r.data,
                     col: col_r, row: row_r, op: ate_pkg::OP_WRITE};
            if (col_wrap) begin
              col_nxt = '0;
              row_nxt = row_end ? rmax[6:0] : row_r + 7'd1;
            end else begin
              col_nxt = col_r + 8'd1;
            end
          end
          ate_pkg::CMD_CTRL: begin
            case (byte_c)
              ate_pkg::B_CR: col_nxt = '0;
              ate_pkg::B_LF: begin
                col_nxt = '0;
                row_nxt = row_end ? rmax[6:0] : row_r + 7'd1;
              end
              ate_pkg::B_BS: if (col_r != 8'd0) col_nxt = col_r - 8'd1;
              ate_pkg::B_TAB: col_nxt = (tab_nt < cols) ? tab_nt[7:0] : cmax[7:0];
              ate_pkg::B_BEL: if (emit_ok) begin
                em_v    = 1'b1;
                em.op   = ate_pkg::OP_BEEP;
              end
              default: ;
            endcase
          end
          ate_pkg::CMD_CSTART: begin
            cnt_nxt  = '0;
            flag_nxt = '0;
            cur_nxt  = '0;
          end
          ate_pkg::CMD_CBODY: begin
            if (byte_c >= 8'h30 && byte_c <= 8'h39) begin
              if (cnt_ok && !flag_r[1])
                cur_nxt = (acc10 > 20'd65535) ? 16'hFFFF : acc10[15:0];
            end else if (byte_c == ate_pkg::B_SEMI) begin
              if (cnt_ok) begin
                we      = 1'b1;
                cnt_nxt = cnt_r + 5'd1;
                cur_nxt = '0;
              end
              flag_nxt[1] = 1'b0;
            end else if (!flag_r[0] && (byte_c == ate_pkg::B_QM ||
                         byte_c == ate_pkg::B_GT || byte_c == ate_pkg::B_EXCL)) begin
              // leading private marker, skipped
            end else begin
              flag_nxt[1] = 1'b1;
              cur_nxt     = '0;
            end
            flag_nxt[0] = 1'b1;
          end
          ate_pkg::CMD_CFINAL: begin
            we    = cnt_ok;
            n_nxt = cnt_ok ? cnt_r + 5'd1 : 5'(ate_pkg::MAX_PARAMS);
          end
          default: ;
        endcase
      end
      ate_pkg::ST_SCROLL: if (emit_ok) begin
        em_v  = 1'b1;
        em.op = ate_pkg::OP_SCROLL;
      end
      ate_pkg::ST_P0: begin
        rd_addr = 4'd0;
        p1_nxt  = '0;
      end
      ate_pkg::ST_P0W: begin
        rd_addr = 4'd1;
        p0_nxt  = p;
        i_nxt   = '0;
      end
      ate_pkg::ST_P1W: p1_nxt = p;
      ate_pkg::ST_APPLY: begin
        case (fin)
          ate_pkg::F_CUU: row_nxt = 7'(ate_pkg::clamp_pos(
                            $signed({11'd0, row_r}) - $signed({2'd0, mv}), {1'b0, rmax}));
          ate_pkg::F_CUD: row_nxt = 7'(ate_pkg::clamp_pos(
                            $signed({11'd0, row_r}) + $signed({2'd0, mv}), {1'b0, rmax}));
          ate_pkg::F_CUF: col_nxt = 8'(ate_pkg::clamp_pos(
                            $signed({10'd0, col_r}) + $signed({2'd0, mv}), cmax));
          ate_pkg::F_CUB: col_nxt = 8'(ate_pkg::clamp_pos(
                            $signed({10'd0, col_r}) - $signed({2'd0, mv}), cmax));
          ate_pkg::F_CHA: col_nxt = 8'(ate_pkg::clamp_pos(
                            $signed({2'd0, mv}) - 18'sd1, cmax));
          ate_pkg::F_CUP, ate_pkg::F_HVP: begin
            row_nxt = 7'(ate_pkg::clamp_pos($signed({2'd0, mv}) - 18'sd1, {1'b0, rmax}));
            col_nxt = 8'(ate_pkg::clamp_pos($signed({2'd0, c1}) - 18'sd1, cmax));
          end
          ate_pkg::F_ED: if (emit_ok && (p0_r == 16'd2 || p0_r == 16'd3)) begin
            em_v    = 1'b1;
            em.op   = ate_pkg::OP_CLEAR_SCREEN;
            col_nxt = '0;
            row_nxt = '0;
          end
          ate_pkg::F_EL: if (emit_ok && p0_r == 16'd2) begin
            em_v   = 1'b1;
            em.op  = ate_pkg::OP_CLEAR_LINE;
            em.row = row_r;
          end
          default: ;
        endcase
      end
      ate_pkg::ST_SG: rd_addr = i_r[3:0];
      ate_pkg::ST_SGW: begin
        rd_addr = 4'(i_r + 5'd1);
        i_nxt   = i_r + 5'd1;
        if (p == 16'd0) begin
          fg_nxt   = ate_pkg::DEFAULT_FG;
          bg_nxt   = ate_pkg::DEFAULT_BG;
          bold_nxt = 1'b0;
        end else if (p == 16'd1) bold_nxt = 1'b1;
        else if (p == 16'd22) bold_nxt = 1'b0;
        else if (p >= 16'd30 && p <= 16'd37) fg_nxt = ate_pkg::palette(p - 16'd30);
        else if (p >= 16'd90 && p <= 16'd97) fg_nxt = ate_pkg::palette(p - 16'd82);
        else if (p == 16'd39) fg_nxt = ate_pkg::DEFAULT_FG;
        else if (p >= 16'd40 && p <= 16'd47) bg_nxt = ate_pkg::palette(p - 16'd40);
        else if (p >= 16'd100 && p <= 16'd107) bg_nxt = ate_pkg::palette(p - 16'd92);
        else if (p == 16'd49) bg_nxt = ate_pkg::DEFAULT_BG;
        else if ((p == 16'd38 || p == 16'd48) && (i_r + 5'd1) < n_r) begin
          ext_fg_nxt = (p == 16'd38);
          i_nxt      = i_r;
        end
      end
      ate_pkg::ST_SG1W: begin
        rd_addr = 4'(i_r + 5'd2);
        if (!(p == 16'd5 && (i_r + 5'd2) < n_r)) i_nxt = i_r + 5'd1;
      end
      ate_pkg::ST_SG2W: begin
        i_nxt = i_r + 5'd3;
        if (ext_fg_r) fg_nxt = ate_pkg::palette(p);
        else bg_nxt = ate_pkg::palette(p);
      end
      ate_pkg::ST_DONE: flush = cmd_r.last && hold_v_r && out_free;
      default: ;
    endcase

    // results pass through a one-deep hold so the final one of a byte gets tlast
    out_v_nxt  = out_v_r && !out_tready;
    out_nxt    = out_r;
    last_nxt   = last_r;
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    if (em_v) begin
      if (hold_v_r) begin
        out_v_nxt = 1'b1;
        out_nxt   = hold_r;
        last_nxt  = 1'b0;
      end
      hold_v_nxt = 1'b1;
      hold_nxt   = em;
    end
    if (flush) begin
      out_v_nxt  = 1'b1;
      out_nxt    = hold_r;
      last_nxt   = 1'b1;
      hold_v_nxt = 1'b0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;
  assign out_tlast  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ate_pkg::ST_IDLE;
      col_r    <= '0;
      row_r    <= '0;
      fg_r     <= ate_pkg::DEFAULT_FG;
      bg_r     <= ate_pkg::DEFAULT_BG;
      bold_r   <= 1'b0;
      cnt_r    <= '0;
      flag_r   <= '0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      fg_r     <= fg_nxt;
      bg_r     <= bg_nxt;
      bold_r   <= bold_nxt;
      cnt_r    <= cnt_nxt;
      flag_r   <= flag_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    cur_r    <= cur_nxt;
    n_r      <= n_nxt;
    i_r      <= i_nxt;
    p0_r     <= p0_nxt;
    p1_r     <= p1_nxt;
    ext_fg_r <= ext_fg_nxt;
    hold_r   <= hold_nxt;
    out_r    <= out_nxt;
    last_r   <= last_nxt;
  end

  // parameter store: one write, one registered read
  always_ff @(posedge clk) begin
    if (we) vals[wa] <= cur_r;
    rdata_r <= vals[rd_addr];
  end

endmodule
`default_nettype wire

### design/ansi_terminal_escape_engine.sv
// Top level of the ANSI terminal escape engine: config registers and wiring.
//
//  channel  | direction | beat contents
//  ---------+-----------+--------------------------------------------------
//  in_*     | in        | one byte of shell output
//  out_*    | out       | one screen command; tlast on the final one of a byte
//  cfg_*    | in/out    | APB registers: 0x0 columns_in_use, 0x4 rows_in_use
//
// The front end takes one byte per cycle while the four-entry command queue
// has room and no second command of a byte waits; a byte makes at most two
// commands (a cut UTF-8 sequence yields U+FFFD ahead of the byte's own action).
// The back end steps a command through IDLE, CLAMP, EXEC, DONE, with SCROLL when
// a wrap scrolls; a CSI final adds P0, P0W and APPLY (P1W for CUP, HVP), or SG and SGW
// per parameter (SG1W, SG2W for 38/48;5;n), paced by the single parameter read port.
// Reset (synchronous, active low) clears the cursor, colors, parser state
// and queue; the parameter store is not cleared.
// A stalled result holds the back end only once its hold slot is also full.
`default_nettype none
module ansi_terminal_escape_engine (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] in_byte
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [87:0]       out_tdata,  // [2:0] op, [9:3] cell_row, [17:10] cell_col,
                                        // [38:18] code_point, [62:39] fore_rgb,
                                        // [86:63] back_rgb, [87] bold_out
  output logic              out_tlast,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [8:0]    cols_r;
  logic [7:0]    rows_r;
  logic          cfg_wr;
  logic          q_push, q_pop, q_empty, q_full;
  ate_pkg::cmd_t q_in, q_head;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  // register select is address bit 2
  assign cfg_prdata = cfg_paddr[2] ? {24'd0, rows_r} : {23'd0, cols_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= 9'd80;
      rows_r <= 8'd24;
    end else if (cfg_wr) begin
      if (cfg_paddr[2]) rows_r <= cfg_pwdata[7:0];
      else cols_r <= cfg_pwdata[8:0];
    end
  end

  ate_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_push    (q_push),
    .q_cmd     (q_in),
    .q_full    (q_full)
  );

  ate_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  ate_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cols_cfg   (cols_r),
    .rows_cfg   (rows_r),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

### design/ate_checker.sv
// Port-level checks on the terminal escape engine, bound to the top level.
`default_nettype none
module ate_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [87:0] out_tdata,
  input wire logic        out_tlast
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_op_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= 3'd4)
    else $error("unknown op code");

  a_attr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != 3'd0 |-> out_tdata[87:39] == '0 && out_tdata[38:10] == '0)
    else $error("non-write command carries cell attributes");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

endmodule

bind ansi_terminal_escape_engine ate_checker u_ate_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire
